FILE: rtl/core/command_frame_segmenter_assert.svh
// Assertion macros shared by the segmenter RTL
`ifndef COMMAND_FRAME_SEGMENTER_ASSERT_SVH
`define COMMAND_FRAME_SEGMENTER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define CFS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define CFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define CFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/core/cfs_pkg.sv
package cfs_pkg;

  localparam int CHUNK_BYTES  = 68;
  localparam int FRAME_BYTES  = 72;
  localparam int HEADER_BYTES = 4;
  localparam int WORDS        = (FRAME_BYTES + 7) / 8;
  // one memory row per output word; row r holds chunk bytes 8r..8r+7
  localparam int RAM_ROWS     = WORDS;
  localparam int ROW_W        = $clog2(RAM_ROWS);
  localparam int FILL_W       = $clog2(CHUNK_BYTES + 1);
  localparam int POS_W        = ROW_W + 3;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h09;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hD7;

  typedef enum logic [0:0] {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_index_t;

  // frame context handed to the word packer
  typedef struct packed {
    logic              first_word;
    logic [ROW_W-1:0]  word_idx;
    logic [FILL_W-1:0] chunk_len;
    logic [7:0]        type_code;
    logic [7:0]        sync_first;
    logic [7:0]        sync_second;
  } pack_ctrl_t;

endpackage

FILE: rtl/core/cfs_word_pack.sv
// Builds one 64-bit frame word: header bytes on the first word, then chunk
// bytes from the low half of the previous row and the high half of the current.
module cfs_word_pack (
  input  cfs_pkg::pack_ctrl_t ctrl,
  input  logic [31:0]         prev_tail,  // chunk bytes 4..7 of the previous row
  input  logic [31:0]         cur_head,   // chunk bytes 0..3 of the current row
  output logic [63:0]         word
);

  always_comb begin
    logic [cfs_pkg::POS_W-1:0] pos;
    logic [cfs_pkg::POS_W-1:0] data_idx;
    logic [7:0]                src;
    logic                      keep;
    word = '0;
    for (int j = 0; j < 8; j++) begin
      pos      = {ctrl.word_idx, 3'(j)};
      data_idx = pos - cfs_pkg::POS_W'(cfs_pkg::HEADER_BYTES);
      if (j < 4) begin
        src = prev_tail[31 - 8*j -: 8];
      end else begin
        src = cur_head[31 - 8*(j-4) -: 8];
      end
      // only bytes written into this chunk, and only inside the frame
      keep = (data_idx < cfs_pkg::POS_W'(ctrl.chunk_len)) &&
             (pos < cfs_pkg::POS_W'(cfs_pkg::FRAME_BYTES));
      if (ctrl.first_word && j < cfs_pkg::HEADER_BYTES) begin
        case (j)
          0:       word[63 - 8*j -: 8] = ctrl.sync_first;
          1:       word[63 - 8*j -: 8] = ctrl.sync_second;
          2:       word[63 - 8*j -: 8] = ctrl.type_code;
          default: word[63 - 8*j -: 8] = 8'(ctrl.chunk_len);
        endcase
      end else if (keep) begin
        word[63 - 8*j -: 8] = src;
      end
    end
  end

endmodule

FILE: rtl/core/command_frame_segmenter.sv
// Command frame segmenter. Takes one datagram byte per cycle on the s_ side
// while collecting. A byte that fills the 68-byte chunk, or that carries
// s_tlast, closes the chunk and starts read-out of one 72-byte frame as nine
// 64-bit words on the m_ side (sync bytes, one-hot type from that byte's
// s_tuser, chunk length, data, zero padding; first frame byte in bits 63:56,
// m_tlast on the ninth word). The chunk sits in a 9-row by 64-bit memory with
// a registered read; read-out first primes that single read port and then
// sends one word per cycle unless m_tready is held low, and s_tready is low
// throughout. Sync bytes are written through cfg_we/cfg_index/cfg_data while
// idle; the user is bound to this, and the block itself does not enforce it.
// No clearing pass is needed after reset.
`include "command_frame_segmenter_assert.svh"

module command_frame_segmenter (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // byte input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_tuser,   // [2:0] source_index
  input  logic        s_tlast,   // datagram_end
  // frame word output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] frame_word
  output logic        m_tlast    // frame_end
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_EMIT    = 2'b10
  } state_t;

  state_t                       state;
  logic [cfs_pkg::FILL_W-1:0]   fill_count;
  logic [cfs_pkg::FILL_W-1:0]   chunk_len;
  logic [7:0]                   type_code;
  logic [7:0]                   sync_first;
  logic [7:0]                   sync_second;
  logic [cfs_pkg::ROW_W-1:0]    word_idx;
  logic [cfs_pkg::ROW_W-1:0]    rd_addr;
  logic                         data_ok;
  logic [63:0]                  rd_row;
  logic [31:0]                  prev_tail;
  logic [63:0]                  chunk_mem [cfs_pkg::RAM_ROWS];
  logic [63:0]                  pack_word;
  cfs_pkg::pack_ctrl_t          pack_ctrl;
  logic                         accept;
  logic                         closing;
  logic                         load;
  logic                         last_word;
  logic [5:0]                   lane_base;

  assign s_tready  = (state == ST_COLLECT);
  assign accept    = s_tvalid && s_tready;
  assign closing   = accept &&
                     (s_tlast || fill_count == cfs_pkg::FILL_W'(cfs_pkg::CHUNK_BYTES - 1));
  assign last_word = (word_idx == cfs_pkg::ROW_W'(cfs_pkg::WORDS - 1));
  assign load      = (state == ST_EMIT) && data_ok && (!m_tvalid || m_tready);
  // byte lane 0 sits in the top bits of a row
  assign lane_base = 6'd56 - {fill_count[2:0], 3'b000};

  // read the next row as soon as the current one is consumed
  always_comb begin
    rd_addr = word_idx;
    if (load && !last_word) begin
      rd_addr = word_idx + cfs_pkg::ROW_W'(1);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= cfs_pkg::SYNC_FIRST_RST;
      sync_second <= cfs_pkg::SYNC_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfs_pkg::CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        cfs_pkg::CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // chunk memory: byte writes, registered row read
  always_ff @(posedge clk) begin
    if (accept) begin
      chunk_mem[fill_count[cfs_pkg::FILL_W-1:3]][lane_base +: 8] <= s_tdata;
    end
    rd_row <= chunk_mem[rd_addr];
  end

  // collect / read-out control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      fill_count <= '0;
      word_idx   <= '0;
      data_ok    <= 1'b0;
    end else begin
      unique case (state)
        ST_COLLECT: begin
          data_ok <= 1'b0;
          if (closing) begin
            state      <= ST_EMIT;
            fill_count <= '0;
            word_idx   <= '0;
          end else if (accept) begin
            fill_count <= fill_count + cfs_pkg::FILL_W'(1);
          end
        end
        ST_EMIT: begin
          data_ok <= 1'b1;
          if (load) begin
            if (last_word) begin
              state    <= ST_COLLECT;
              word_idx <= '0;
              data_ok  <= 1'b0;
            end else begin
              word_idx <= word_idx + cfs_pkg::ROW_W'(1);
            end
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

  // frame context of the chunk being sent
  always_ff @(posedge clk) begin
    if (closing) begin
      chunk_len <= fill_count + cfs_pkg::FILL_W'(1);
      type_code <= 8'(9'd1 << s_tuser);
    end
    if (load) begin
      prev_tail <= rd_row[31:0];
    end
  end

  assign pack_ctrl = '{
    first_word:  (word_idx == '0),
    word_idx:    word_idx,
    chunk_len:   chunk_len,
    type_code:   type_code,
    sync_first:  sync_first,
    sync_second: sync_second
  };

  cfs_word_pack u_pack (
    .ctrl      (pack_ctrl),
    .prev_tail (prev_tail),
    .cur_head  (rd_row[63:32]),
    .word      (pack_word)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= pack_word;
      m_tlast <= last_word;
    end
  end

  `CFS_ASSERT_IMPLY(a_fill_in_range, clk, rst, s_tready, fill_count < cfs_pkg::FILL_W'(cfs_pkg::CHUNK_BYTES), "fill count beyond chunk while taking bytes")
  `CFS_ASSERT_NEXT(a_close_primes, clk, rst, closing, (state == ST_EMIT) && !data_ok && (word_idx == '0), "chunk close did not start read-out cleanly")
  `CFS_ASSERT_IMPLY(a_word_in_range, clk, rst, 1'b1, word_idx <= cfs_pkg::ROW_W'(cfs_pkg::WORDS - 1), "word index past end of frame")
  `CFS_ASSERT_NEXT(a_last_frees_input, clk, rst, load && last_word, state == ST_COLLECT, "read-out did not end after the final word")

endmodule
